/* src/utf8_scrub_replace_invalid_core_macros.svh */
// Assertion macros for the UTF-8 scrubber core.
`ifndef UTF8_SCRUB_REPLACE_INVALID_CORE_MACROS_SVH
`define UTF8_SCRUB_REPLACE_INVALID_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define UTF8S_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("utf8 scrubber: implication failed");
// next-cycle implication
`define UTF8S_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("utf8 scrubber: next-cycle implication failed");
`else
`define UTF8S_ASSERT_IMP(name, clk, rst, ante, cons)
`define UTF8S_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

/* src/utf8s_pkg.sv */
// Shared types, constants and byte classification for the UTF-8 scrubber.
package utf8s_pkg;

   localparam logic [7:0] REPL_BYTE   = 8'h3F;
   localparam logic [7:0] LEAD1_LIMIT = 8'h80;
   localparam logic [7:0] LEAD2_MIN   = 8'hC2;
   localparam logic [7:0] LEAD3_MIN   = 8'hE0;
   localparam logic [7:0] LEAD4_MIN   = 8'hF0;
   localparam logic [7:0] LEAD4_MAX   = 8'hF4;
   localparam logic [7:0] LEAD_E0     = 8'hE0;
   localparam logic [7:0] LEAD_ED     = 8'hED;
   localparam logic [7:0] LEAD_F0     = 8'hF0;
   localparam logic [7:0] LEAD_F4     = 8'hF4;
   localparam logic [7:0] CONT_MASK   = 8'hC0;
   localparam logic [7:0] CONT_TAG    = 8'h80;
   localparam logic [7:0] SECOND_A0   = 8'hA0;
   localparam logic [7:0] SECOND_90   = 8'h90;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   localparam logic [31:0] CAP_RESET = 32'd4096;

   // All results caused by one input transaction.
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      count;       // results in the bundle, 1..4
      logic            present;     // 0 on a bare done marker
      logic            final_item;
      logic [31:0]     total;
   } bundle_type;

   // 0 means the byte cannot start a sequence
   function automatic logic [2:0] lead_length(input logic [7:0] b);
      priority if (b < LEAD1_LIMIT) return 3'd1;
      else if (b >= LEAD2_MIN && b < LEAD3_MIN) return 3'd2;
      else if (b >= LEAD3_MIN && b < LEAD4_MIN) return 3'd3;
      else if (b >= LEAD4_MIN && b <= LEAD4_MAX) return 3'd4;
      else return 3'd0;
   endfunction

   function automatic logic cont_ok(input logic [7:0] lead, input logic [1:0] pos,
                                    input logic [7:0] b);
      logic ok;
      ok = ((b & CONT_MASK) == CONT_TAG);
      if (pos == 2'd1) begin
         if (lead == LEAD_E0 && b < SECOND_A0) ok = 1'b0;
         if (lead == LEAD_ED && b >= SECOND_A0) ok = 1'b0;
         if (lead == LEAD_F0 && b < SECOND_90) ok = 1'b0;
         if (lead == LEAD_F4 && b >= SECOND_90) ok = 1'b0;
      end
      return ok;
   endfunction

endpackage

/* src/utf8s_req_if.sv */
// Input byte channel.
interface utf8s_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       is_final;

   modport source (output valid, output in_byte, output is_final, input ready);
   modport sink   (input valid, input in_byte, input is_final, output ready);
endinterface

/* src/utf8s_rsp_if.sv */
// Result byte channel.
interface utf8s_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        byte_present;
   logic        run_last;
   logic        done_res;
   logic [31:0] total_written;

   modport source (output valid, output out_byte, output byte_present, output run_last,
                   output done_res, output total_written, input ready);
   modport sink   (input valid, input out_byte, input byte_present, input run_last,
                   input done_res, input total_written, output ready);
endinterface

/* src/utf8s_front.sv */
// Front end: parses each byte, tracks the pending sequence and the output budget.
module utf8s_front
   import utf8s_pkg::*;
#(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   utf8s_req_if.sink              req_bus,
   input  logic [COUNT_WIDTH-1:0] cap,
   output logic                   push_valid,
   output bundle_type             push_data,
   input  logic                   push_ready
);

   logic [2:0][7:0]        held_ff, held_in;
   logic [1:0]             hc_ff, hc_in;
   logic [2:0]             sl_ff, sl_in;
   logic [COUNT_WIDTH-1:0] wc_ff, wc_in;
   logic                   stopped_ff, stopped_in;

   logic [7:0]             b;
   logic                   fin, accept;
   logic                   pending, ok, complete, store, relead;
   logic [2:0]             len;
   logic                   lead_emit, lead_hold, last_is_b, fits;
   logic [2:0]             pre_repl, fin_flush, k, room_small, n_out;
   logic [COUNT_WIDTH-1:0] room_full, wc_next;
   logic [63:0]            wc_wide;
   logic                   stop_new;

   assign b      = req_bus.in_byte;
   assign fin    = req_bus.is_final;
   assign req_bus.ready = push_ready;
   assign accept = req_bus.valid && push_ready;

   always_comb begin
      pending  = (hc_ff != 2'd0) && (sl_ff >= 3'd2) && (sl_ff <= 3'd4);
      ok       = cont_ok(held_ff[0], hc_ff, b);
      complete = pending && ok && (({1'b0, hc_ff} + 3'd1) == sl_ff);
      store    = pending && ok && !complete;
      relead   = !pending || !ok;
      len      = lead_length(b);

      lead_emit = relead && (len < 3'd2);
      lead_hold = relead && (len >= 3'd2);
      last_is_b = relead && (len == 3'd1);
      pre_repl  = (relead && pending) ? {1'b0, hc_ff} : 3'd0;
      if (!fin)           fin_flush = 3'd0;
      else if (store)     fin_flush = {1'b0, hc_ff} + 3'd1;
      else if (lead_hold) fin_flush = 3'd1;
      else                fin_flush = 3'd0;
      k = pre_repl + {2'b00, lead_emit} + fin_flush;

      // room left under the cap, clipped to the largest run of one step
      room_full = cap - wc_ff;
      if (stopped_ff || cap <= wc_ff) room_small = 3'd0;
      else if (room_full > COUNT_WIDTH'(4)) room_small = 3'd4;
      else room_small = room_full[2:0];

      fits = 1'b0;
      if (complete) begin
         fits     = !stopped_ff && (sl_ff <= room_small);
         n_out    = fits ? sl_ff : 3'd0;
         stop_new = stopped_ff || !fits;
      end else begin
         n_out    = (k <= room_small) ? k : room_small;
         stop_new = stopped_ff || (k > room_small);
      end

      wc_next = wc_ff + COUNT_WIDTH'(n_out);
      wc_wide = 64'(wc_next);

      push_data = '0;
      for (int i = 0; i < 4; i++) begin
         if (complete) begin
            if (i < 3) push_data.bytes[i] = (2'(i) == hc_ff) ? b : held_ff[i];
            else       push_data.bytes[i] = b;
         end else begin
            push_data.bytes[i] = (last_is_b && (3'(i) == k - 3'd1)) ? b : REPL_BYTE;
         end
      end
      push_data.count      = (n_out == 3'd0) ? 3'd1 : n_out;
      push_data.present    = (n_out != 3'd0);
      push_data.final_item = fin;
      push_data.total      = fin ? wc_wide[31:0] : 32'd0;
      push_valid = accept && ((n_out != 3'd0) || fin);

      // state update for an accepted transaction
      held_in = held_ff;
      for (int i = 0; i < 3; i++) begin
         if (store && hc_ff == 2'(i)) held_in[i] = b;
      end
      if (lead_hold) held_in[0] = b;

      if (fin || complete) begin
         hc_in = 2'd0;
         sl_in = 3'd0;
      end else if (store) begin
         hc_in = hc_ff + 2'd1;
         sl_in = sl_ff;
      end else if (lead_hold) begin
         hc_in = 2'd1;
         sl_in = len;
      end else begin
         hc_in = 2'd0;
         sl_in = 3'd0;
      end
      wc_in      = fin ? '0 : wc_next;
      stopped_in = fin ? 1'b0 : stop_new;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hc_ff      <= 2'd0;
         sl_ff      <= 3'd0;
         wc_ff      <= '0;
         stopped_ff <= 1'b0;
      end else if (accept) begin
         hc_ff      <= hc_in;
         sl_ff      <= sl_in;
         wc_ff      <= wc_in;
         stopped_ff <= stopped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) held_ff <= held_in;
   end

endmodule

/* src/utf8s_queue.sv */
// Short bundle queue between the front end and the output serialiser.
module utf8s_queue
   import utf8s_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push_valid,
   input  bundle_type push_data,
   output logic       push_ready,
   output logic       pop_valid,
   output bundle_type pop_data,
   input  logic       pop_ready
);

   bundle_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]    count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != (QPTR_W + 1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W + 1)'(do_push) - (QPTR_W + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_data;
   end

endmodule

/* src/utf8s_back.sv */
// Back end: serialises each bundle into result transactions, one per cycle while rsp_bus is ready.
module utf8s_back
   import utf8s_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       pop_valid,
   input  bundle_type pop_data,
   output logic       pop_ready,
   utf8s_rsp_if.source rsp_bus
);

   bundle_type cur_ff, cur_in;
   logic       cur_valid_ff, cur_valid_in;
   logic [1:0] idx_ff, idx_in;
   logic       last, take, load;

   assign last      = ({1'b0, idx_ff} == cur_ff.count - 3'd1);
   assign take      = cur_valid_ff && rsp_bus.ready;
   assign pop_ready = !cur_valid_ff || (take && last);
   assign load      = pop_ready && pop_valid;

   assign rsp_bus.valid         = cur_valid_ff;
   assign rsp_bus.out_byte      = cur_ff.present ? cur_ff.bytes[idx_ff] : 8'd0;
   assign rsp_bus.byte_present  = cur_ff.present;
   assign rsp_bus.run_last      = last;
   assign rsp_bus.done_res      = cur_ff.final_item && last;
   assign rsp_bus.total_written = (cur_ff.final_item && last) ? cur_ff.total : 32'd0;

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      priority if (load) begin
         cur_in       = pop_data;
         cur_valid_in = 1'b1;
         idx_in       = 2'd0;
      end else if (take && last) begin
         cur_valid_in = 1'b0;
      end else if (take) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule

/* src/utf8_scrub_replace_invalid_core.sv */
// UTF-8 scrubber: one byte per cycle in while the bundle queue has room; a completed sequence
// leaves one byte per cycle while the result channel is ready. An input's results are held in
// the queue, then in the serialiser; one causing n results holds the serialiser until all n are
// taken. The four-entry bundle queue sets how far input may run ahead of the output side.
// Reset (synchronous): clears stream state and queue; capacity returns to 4096.
`include "utf8_scrub_replace_invalid_core_macros.svh"
module utf8_scrub_replace_invalid_core
   import utf8s_pkg::*;
#(
   parameter int COUNT_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   utf8s_req_if.sink   req_bus,
   utf8s_rsp_if.source rsp_bus,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [31:0]            cfg_ff;
   logic [COUNT_WIDTH-1:0] cap_ff;
   logic                   cfg_write;

   logic       push_valid, push_ready, pop_valid, pop_ready;
   bundle_type push_data, pop_data;

   // saturate the capacity to the counter range
   function automatic logic [COUNT_WIDTH-1:0] sat_cap(input logic [31:0] v);
      logic [63:0] wide;
      logic [63:0] mask;
      wide = {32'd0, v};
      mask = {64{1'b1}} >> (64 - COUNT_WIDTH);
      return (wide > mask) ? mask[COUNT_WIDTH-1:0] : wide[COUNT_WIDTH-1:0];
   endfunction

   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == 1'b0);
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? cfg_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CAP_RESET;
         cap_ff <= sat_cap(CAP_RESET);
      end else if (cfg_write) begin
         cfg_ff <= csr_pwdata;
         cap_ff <= sat_cap(csr_pwdata);
      end
   end

   utf8s_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .cap        (cap_ff),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready)
   );

   utf8s_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   utf8s_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop_ready (pop_ready),
      .rsp_bus   (rsp_bus)
   );

   `UTF8S_ASSERT_IMP(a_done_is_run_last, clock, reset, rsp_bus.valid && rsp_bus.done_res, rsp_bus.run_last)
   `UTF8S_ASSERT_IMP(a_bare_marker_is_done, clock, reset, rsp_bus.valid && !rsp_bus.byte_present, rsp_bus.done_res)
   `UTF8S_ASSERT_IMP(a_total_only_on_done, clock, reset, rsp_bus.valid && (rsp_bus.total_written != 32'd0), rsp_bus.done_res)
   `UTF8S_ASSERT_NEXT(a_cfg_readback, clock, reset, cfg_write, (csr_paddr[2] != 1'b0) || (csr_prdata == $past(csr_pwdata)))

endmodule
